### src/blfm_pkg.sv
// Package: payload types, flag positions, register indexes and reset values.
`timescale 1ns / 1ps

package blfm_pkg;

    localparam int unsigned FLAG_W = 9;
    localparam int unsigned CFG_W  = 16;

    // flag bit positions
    localparam int unsigned F_EMPTY    = 0;
    localparam int unsigned F_VLOW     = 1;
    localparam int unsigned F_VHIGH    = 2;
    localparam int unsigned F_CHG_CUR  = 3;
    localparam int unsigned F_DRV_CUR  = 4;
    localparam int unsigned F_CHG_HOT  = 5;
    localparam int unsigned F_CHG_COLD = 6;
    localparam int unsigned F_DRV_HOT  = 7;
    localparam int unsigned F_DRV_COLD = 8;

    localparam logic signed [15:0] DRIVE_COLD_LIMIT  = -16'sd2000;
    localparam logic signed [15:0] CHARGE_COLD_LIMIT = 16'sd0;

    typedef enum logic [1:0] {
        PH_DRIVE  = 2'd0,
        PH_CHARGE = 2'd1,
        PH_SYM    = 2'd2,
        PH_OTHER  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        REG_DRV_CUTOFF_V = 3'd0,
        REG_DRV_EMPTY_V  = 3'd1,
        REG_HIGH_V       = 3'd2,
        REG_CHG_LOW_V    = 3'd3,
        REG_DRV_CUR_LIM  = 3'd4,
        REG_SYM_CUR_LIM  = 3'd5,
        REG_CHG_TEMP_MAX = 3'd6,
        REG_DRV_TEMP_MAX = 3'd7
    } t_reg_idx;

    localparam logic [15:0]        RST_DRV_CUTOFF_V = 16'd32600;
    localparam logic [15:0]        RST_DRV_EMPTY_V  = 16'd33600;
    localparam logic [15:0]        RST_HIGH_V       = 16'd37500;
    localparam logic [15:0]        RST_CHG_LOW_V    = 16'd31000;
    localparam logic signed [15:0] RST_DRV_CUR_LIM  = -16'sd2000;
    localparam logic signed [15:0] RST_SYM_CUR_LIM  = 16'sd28;
    localparam logic signed [15:0] RST_CHG_TEMP_MAX = 16'sd4500;
    localparam logic signed [15:0] RST_DRV_TEMP_MAX = 16'sd5500;

    typedef struct packed {
        logic [1:0]         phase;
        logic [15:0]        pack_voltage;
        logic signed [15:0] pack_current;
        logic signed [15:0] cell_temp_min;
        logic signed [15:0] cell_temp_max;
    } t_blfm_in;

    typedef struct packed {
        logic [FLAG_W-1:0] status_flags;
        logic              power_off_request;
    } t_blfm_out;

endpackage

### src/battery_limit_flag_monitor_top.sv
// Top level: battery limit flag monitor with sticky flags and skid output.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------
//  in      | in        | i_in_valid / o_in_stall | i_in_data (t_blfm_in)
//  out     | out       | o_out_valid/ i_out_stall| o_out_data (t_blfm_out)
//  cfg     | in        | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One item per cycle while o_in_stall is low; its result is registered in the output
// register, or in the skid entry while a result is stalled. The flag update is a single
// layer of compares against the limit registers. A one-entry skid behind the output
// register lets an item be taken while a result is stalled; o_in_stall rises only when both entries are full.
// Synchronous active-low reset clears flags, valids and restores the limits.
`timescale 1ns / 1ps

module battery_limit_flag_monitor_top
    import blfm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_blfm_in         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_blfm_out        o_out_data,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [15:0]        r_drv_cutoff_v;
    logic [15:0]        r_drv_empty_v;
    logic [15:0]        r_high_v;
    logic [15:0]        r_chg_low_v;
    logic signed [15:0] r_drv_cur_lim;
    logic signed [15:0] r_sym_cur_lim;
    logic signed [15:0] r_chg_temp_max;
    logic signed [15:0] r_drv_temp_max;

    logic [FLAG_W-1:0] r_flags;
    logic [FLAG_W-1:0] n_flags;
    logic              n_poff;
    t_blfm_out         n_res;

    logic      r_out_valid;
    t_blfm_out r_out;
    logic      r_skid_valid;
    t_blfm_out r_skid;

    logic accept;
    logic out_take;

    assign accept   = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drv_cutoff_v <= RST_DRV_CUTOFF_V;
            r_drv_empty_v  <= RST_DRV_EMPTY_V;
            r_high_v       <= RST_HIGH_V;
            r_chg_low_v    <= RST_CHG_LOW_V;
            r_drv_cur_lim  <= RST_DRV_CUR_LIM;
            r_sym_cur_lim  <= RST_SYM_CUR_LIM;
            r_chg_temp_max <= RST_CHG_TEMP_MAX;
            r_drv_temp_max <= RST_DRV_TEMP_MAX;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DRV_CUTOFF_V: r_drv_cutoff_v <= i_cfg_data;
                REG_DRV_EMPTY_V:  r_drv_empty_v  <= i_cfg_data;
                REG_HIGH_V:       r_high_v       <= i_cfg_data;
                REG_CHG_LOW_V:    r_chg_low_v    <= i_cfg_data;
                REG_DRV_CUR_LIM:  r_drv_cur_lim  <= signed'(i_cfg_data);
                REG_SYM_CUR_LIM:  r_sym_cur_lim  <= signed'(i_cfg_data);
                REG_CHG_TEMP_MAX: r_chg_temp_max <= signed'(i_cfg_data);
                REG_DRV_TEMP_MAX: r_drv_temp_max <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // flag update for the item on the input port
    always_comb begin
        n_flags = r_flags;
        n_poff  = 1'b0;
        case (t_phase'(i_in_data.phase))
            PH_DRIVE: begin
                n_flags[F_DRV_COLD] = i_in_data.cell_temp_min < DRIVE_COLD_LIMIT;
                n_flags[F_DRV_HOT]  = i_in_data.cell_temp_max >= r_drv_temp_max;
                if (i_in_data.pack_voltage < r_drv_cutoff_v) begin
                    n_poff = 1'b1;              // voltage flags hold
                end else if (i_in_data.pack_voltage < r_drv_empty_v) begin
                    n_flags[F_EMPTY] = 1'b1;
                    n_flags[F_VLOW]  = 1'b1;
                    n_flags[F_VHIGH] = 1'b0;
                end else begin
                    n_flags[F_VLOW]  = 1'b0;
                    n_flags[F_VHIGH] = i_in_data.pack_voltage >= r_high_v;
                end
                n_flags[F_CHG_CUR] = 1'b0;
                n_flags[F_DRV_CUR] = i_in_data.pack_current <= r_drv_cur_lim;
            end
            PH_CHARGE: begin
                n_flags[F_CHG_COLD] = i_in_data.cell_temp_min < CHARGE_COLD_LIMIT;
                n_flags[F_CHG_HOT]  = i_in_data.cell_temp_max >= r_chg_temp_max;
                if (i_in_data.pack_voltage < r_chg_low_v) begin
                    n_flags[F_VLOW]  = 1'b1;
                    n_flags[F_VHIGH] = 1'b0;
                end else begin
                    n_flags[F_VLOW]  = 1'b0;
                    n_flags[F_VHIGH] = i_in_data.pack_voltage >= r_high_v;
                end
                n_flags[F_CHG_CUR] = 1'b0;
                n_flags[F_DRV_CUR] = i_in_data.pack_current <= r_drv_cur_lim;
            end
            PH_SYM: begin
                n_flags[F_CHG_CUR] = i_in_data.pack_current > r_sym_cur_lim;
            end
            default: ;
        endcase
        n_res.status_flags      = n_flags;
        n_res.power_off_request = n_poff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_flags <= n_flags;
            end
            if (out_take) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else if (accept) begin
                    r_out <= n_res;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (accept) begin
                if (!r_out_valid) begin
                    r_out       <= n_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= n_res;
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### src/blfm_checker.sv
// Checker: port-level properties of the flag monitor, bound to the top level.
`timescale 1ns / 1ps

module blfm_checker
    import blfm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_blfm_out o_out_data
);

    // reset empties both output entries
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output not empty after reset");

    // input can only stall when a result is waiting
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // item taken into an empty output shows a result next cycle
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> o_out_valid)
        else $error("accepted item produced no result");

    // item taken behind a stalled result fills the skid
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && o_out_valid && i_out_stall |=> o_in_stall)
        else $error("skid entry not held");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind battery_limit_flag_monitor_top blfm_checker u_blfm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### bench/battery_limit_flag_monitor_top_tb.sv
// Testbench: random and directed measurement sets checked against a flag predictor.
`timescale 1ns / 1ps

module battery_limit_flag_monitor_top_tb;
    import blfm_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 60;
    localparam int unsigned MAX_REPORTS    = 10;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_blfm_in         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_blfm_out        o_out_data;
    logic             i_cfg_we = 1'b0;
    logic [2:0]       i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    // limit shadow and flag state of the predictor
    logic [15:0]        cutoff_v   = RST_DRV_CUTOFF_V;
    logic [15:0]        empty_v    = RST_DRV_EMPTY_V;
    logic [15:0]        high_v     = RST_HIGH_V;
    logic [15:0]        chg_low_v  = RST_CHG_LOW_V;
    logic signed [15:0] drv_cur_lim = RST_DRV_CUR_LIM;
    logic signed [15:0] sym_cur_lim = RST_SYM_CUR_LIM;
    logic signed [15:0] chg_tmax    = RST_CHG_TEMP_MAX;
    logic signed [15:0] drv_tmax    = RST_DRV_TEMP_MAX;
    logic [FLAG_W-1:0]  flags_model = '0;

    t_blfm_in  pending_items[$];
    t_blfm_out expected_flags[$];

    int unsigned send_idle_pct = 25;
    int unsigned recv_idle_pct = 25;
    int unsigned hold_req = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned quiet_cycles = 0;

    battery_limit_flag_monitor_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one measurement set to the flag state, returns the emitted result.
    function automatic t_blfm_out update_flags(t_blfm_in m);
        logic [FLAG_W-1:0]  f;
        logic               poff;
        logic signed [15:0] cur;
        logic signed [15:0] tmin;
        logic signed [15:0] tmax;
        t_blfm_out          r;
        f    = flags_model;
        poff = 1'b0;
        cur  = m.pack_current;
        tmin = m.cell_temp_min;
        tmax = m.cell_temp_max;
        case (t_phase'(m.phase))
            PH_DRIVE: begin
                f[F_DRV_COLD] = tmin < DRIVE_COLD_LIMIT;
                f[F_DRV_HOT]  = tmax >= drv_tmax;
                if (m.pack_voltage < cutoff_v) begin
                    poff = 1'b1;    // voltage flags frozen
                end else if (m.pack_voltage < empty_v) begin
                    f[F_EMPTY] = 1'b1;
                    f[F_VLOW]  = 1'b1;
                    f[F_VHIGH] = 1'b0;
                end else begin
                    f[F_VLOW]  = 1'b0;
                    f[F_VHIGH] = m.pack_voltage >= high_v;
                end
                f[F_CHG_CUR] = 1'b0;
                f[F_DRV_CUR] = cur <= drv_cur_lim;
            end
            PH_CHARGE: begin
                f[F_CHG_COLD] = tmin < CHARGE_COLD_LIMIT;
                f[F_CHG_HOT]  = tmax >= chg_tmax;
                if (m.pack_voltage < chg_low_v) begin
                    f[F_VLOW]  = 1'b1;
                    f[F_VHIGH] = 1'b0;
                end else begin
                    f[F_VLOW]  = 1'b0;
                    f[F_VHIGH] = m.pack_voltage >= high_v;
                end
                f[F_CHG_CUR] = 1'b0;
                f[F_DRV_CUR] = cur <= drv_cur_lim;
            end
            PH_SYM: begin
                f[F_CHG_CUR] = cur > sym_cur_lim;
            end
            default: ;
        endcase
        flags_model         = f;
        r.status_flags      = f;
        r.power_off_request = poff;
        return r;
    endfunction

    task automatic log_mismatch(string what, int unsigned want, int unsigned got);
        if (mismatch_cnt < MAX_REPORTS) begin
            $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
        end
        mismatch_cnt++;
    endtask

    // sender: tracks limit writes, predicts accepted items, offers the next one
    always @(posedge i_clk) begin : sender
        logic offer;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_DRV_CUTOFF_V: cutoff_v    = i_cfg_data;
                    REG_DRV_EMPTY_V:  empty_v     = i_cfg_data;
                    REG_HIGH_V:       high_v      = i_cfg_data;
                    REG_CHG_LOW_V:    chg_low_v   = i_cfg_data;
                    REG_DRV_CUR_LIM:  drv_cur_lim = i_cfg_data;
                    REG_SYM_CUR_LIM:  sym_cur_lim = i_cfg_data;
                    REG_CHG_TEMP_MAX: chg_tmax    = i_cfg_data;
                    REG_DRV_TEMP_MAX: drv_tmax    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                expected_flags.push_back(update_flags(i_in_data));
            end
            if (!i_in_valid || !o_in_stall) begin
                offer = (pending_items.size() > 0) &&
                        ($urandom_range(0, 99) >= send_idle_pct);
                if (offer) begin
                    i_in_data <= pending_items.pop_front();
                end
                i_in_valid <= offer;
            end
        end
    end

    // receiver: checks results in order, stalls at random or for a hold-off
    always @(posedge i_clk) begin : receiver
        t_blfm_out want;
        logic      stall_nxt;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_flags.size() == 0) begin
                    log_mismatch("result with no item outstanding", 0, 32'(o_out_data));
                end else begin
                    want = expected_flags.pop_front();
                    if (o_out_data.status_flags !== want.status_flags) begin
                        log_mismatch("status_flags", 32'(want.status_flags),
                                     32'(o_out_data.status_flags));
                    end
                    if (o_out_data.power_off_request !== want.power_off_request) begin
                        log_mismatch("power_off_request", 32'(want.power_off_request),
                                     32'(o_out_data.power_off_request));
                    end
                end
            end
            if (hold_served != hold_req) begin
                hold_served = hold_req;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                stall_nxt = 1'b1;
                hold_left--;
            end else begin
                stall_nxt = $urandom_range(0, 99) < recv_idle_pct;
            end
            i_out_stall <= stall_nxt;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_item(t_phase ph, logic [15:0] volt, logic [15:0] cur,
                              logic [15:0] tmin, logic [15:0] tmax);
        t_blfm_in it;
        it.phase         = ph;
        it.pack_voltage  = volt;
        it.pack_current  = cur;
        it.cell_temp_min = tmin;
        it.cell_temp_max = tmax;
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] around(logic [15:0] base);
        return base + 16'($urandom_range(0, 6)) - 16'd3;
    endfunction

    task automatic queue_random(int unsigned n);
        t_phase      ph;
        logic [15:0] volt;
        logic [15:0] cur;
        logic [15:0] tmin;
        logic [15:0] tmax;
        int unsigned r;
        repeat (n) begin
            r = $urandom_range(0, 9);
            ph = (r < 4) ? PH_DRIVE : (r < 7) ? PH_CHARGE : (r < 9) ? PH_SYM : PH_OTHER;
            case ($urandom_range(0, 4))
                0:       volt = 16'($urandom);
                1:       volt = around(cutoff_v);
                2:       volt = around(empty_v);
                3:       volt = around(high_v);
                default: volt = around(chg_low_v);
            endcase
            case ($urandom_range(0, 3))
                0:       cur = 16'($urandom);
                1:       cur = around(drv_cur_lim);
                2:       cur = around(sym_cur_lim);
                default: cur = 16'($urandom_range(0, 6000)) - 16'd3000;
            endcase
            case ($urandom_range(0, 3))
                0:       tmin = 16'($urandom);
                1:       tmin = around(DRIVE_COLD_LIMIT);
                2:       tmin = around(CHARGE_COLD_LIMIT);
                default: tmin = 16'($urandom_range(0, 6000)) - 16'd3000;
            endcase
            case ($urandom_range(0, 2))
                0:       tmax = 16'($urandom);
                1:       tmax = around(chg_tmax);
                default: tmax = around(drv_tmax);
            endcase
            queue_item(ph, volt, cur, tmin, tmax);
        end
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
    endtask

    task automatic load_limits(logic [15:0] cut, logic [15:0] empty, logic [15:0] high,
                               logic [15:0] chg_low, logic [15:0] dcur, logic [15:0] scur,
                               logic [15:0] ctmax, logic [15:0] dtmax);
        write_reg(REG_DRV_CUTOFF_V, cut);
        write_reg(REG_DRV_EMPTY_V, empty);
        write_reg(REG_HIGH_V, high);
        write_reg(REG_CHG_LOW_V, chg_low);
        write_reg(REG_DRV_CUR_LIM, dcur);
        write_reg(REG_SYM_CUR_LIM, scur);
        write_reg(REG_CHG_TEMP_MAX, ctmax);
        write_reg(REG_DRV_TEMP_MAX, dtmax);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic randomize_limits();
        logic [15:0] cut;
        cut = 16'(30000 + $urandom_range(0, 4000));
        if ($urandom_range(0, 3) == 0) begin
            load_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            load_limits(cut, cut + 16'($urandom_range(0, 2000)),
                        16'(36000 + $urandom_range(0, 3000)),
                        16'(29000 + $urandom_range(0, 4000)),
                        16'(-int'($urandom_range(0, 4000))),
                        16'(int'($urandom_range(0, 100)) - 50),
                        16'(3000 + $urandom_range(0, 3000)),
                        16'(4000 + $urandom_range(0, 3000)));
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_in_valid || expected_flags.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial begin : stimulus
        int unsigned ph;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset limits: band edges, field extremes, every phase
        queue_item(PH_DRIVE, 16'd37500, 16'd0, 16'd2000, 16'd2000);
        queue_item(PH_DRIVE, 16'd0, -16'sd2000, -16'sd2000, 16'd5500);
        queue_item(PH_DRIVE, 16'd32599, -16'sd1999, -16'sd2001, 16'd5499);
        queue_item(PH_DRIVE, 16'd32600, 16'h8000, 16'h8000, 16'h7fff);
        queue_item(PH_DRIVE, 16'd33599, 16'h7fff, 16'h7fff, 16'h8000);
        queue_item(PH_DRIVE, 16'd33600, 16'd0, 16'd0, 16'd0);
        queue_item(PH_DRIVE, 16'd37499, -16'sd2000, -16'sd1, 16'd5500);
        queue_item(PH_DRIVE, 16'hffff, -16'sd2001, -16'sd2000, 16'd5501);
        queue_item(PH_CHARGE, 16'd30999, 16'd0, -16'sd1, 16'd4500);
        queue_item(PH_CHARGE, 16'd31000, -16'sd2000, 16'd0, 16'd4499);
        queue_item(PH_CHARGE, 16'd37500, 16'h7fff, 16'h8000, 16'h7fff);
        queue_item(PH_CHARGE, 16'd0, 16'h8000, 16'h7fff, 16'h8000);
        queue_item(PH_CHARGE, 16'hffff, 16'd100, 16'd100, 16'd100);
        queue_item(PH_SYM, 16'd0, 16'd29, 16'h8000, 16'h8000);
        queue_item(PH_SYM, 16'hffff, 16'd28, 16'h7fff, 16'h7fff);
        queue_item(PH_SYM, 16'd35000, 16'h7fff, 16'd0, 16'd0);
        queue_item(PH_SYM, 16'd35000, 16'h8000, 16'd0, 16'd0);
        queue_item(PH_OTHER, 16'd0, 16'h8000, 16'h8000, 16'h8000);
        queue_item(PH_OTHER, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff);
        // below cutoff after a high reading: voltage flags must hold
        queue_item(PH_DRIVE, 16'd38000, 16'd0, 16'd2000, 16'd2000);
        queue_item(PH_DRIVE, 16'd30000, 16'd0, 16'd2000, 16'd2000);
        // sym overcurrent is cleared by the next drive item
        queue_item(PH_SYM, 16'd35000, 16'd100, 16'd0, 16'd0);
        queue_item(PH_DRIVE, 16'd35000, 16'd0, 16'd2000, 16'd2000);
        wait_idle();

        load_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_random(40);
        wait_idle();

        load_limits(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                    16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        queue_random(40);
        wait_idle();

        // thresholds out of their usual order
        load_limits(16'd36000, 16'd33000, 16'd31000, 16'd37000,
                    16'd500, -16'sd500, -16'sd100, -16'sd3000);
        queue_random(40);
        wait_idle();

        for (ph = 0; ph < 7; ph++) begin
            randomize_limits();
            if (ph == 1) begin
                set_idling(0, 0);
            end else if (ph == 3) begin
                set_idling(0, 25);
            end else begin
                set_idling(25, 25);
            end
            queue_random(100);
            if (ph == 3) begin
                @(negedge i_clk);
                hold_req++;
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_flags.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
src/blfm_pkg.sv
src/battery_limit_flag_monitor_top.sv
src/blfm_checker.sv
bench/battery_limit_flag_monitor_top_tb.sv
